@@ hdl/mske_pkg.sv @@
// Package for the motor speed Kalman estimator: beat payload types, sequencer
// states, register indexes and the saturation helper. Depends on nothing.
`default_nettype none

package mske_pkg;

    localparam int TIME_FRAC = 16;
    localparam int ACC_W     = 68;

    localparam logic [0:0] MODE_REPORT = 1'b0;
    localparam logic [0:0] MODE_QUERY  = 1'b1;

    localparam logic [1:0] REG_SPEED_SCALE = 2'd0;
    localparam logic [1:0] REG_NOISE_VEL   = 2'd1;
    localparam logic [1:0] REG_NOISE_ACC   = 2'd2;
    localparam logic [1:0] REG_NOISE_MEAS  = 2'd3;

    typedef struct packed {
        logic [0:0]         mode;
        logic [47:0]        time_stamp;
        logic signed [31:0] measured_speed;
        logic [15:0]        supply_voltage_in;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] velocity_estimate;
        logic               correction_skipped;
        logic [15:0]        supply_voltage;
        logic               voltage_known;
    } out_beat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TIME,
        ST_P0,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_P4,
        ST_EST,
        ST_C0,
        ST_C1,
        ST_CD0,
        ST_CD1,
        ST_C2,
        ST_C3,
        ST_C4,
        ST_C5,
        ST_C6,
        ST_C7,
        ST_FIN
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = ACC_W'(-64'sd2147483648);
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/motor_speed_kalman_estimator_top.sv @@
// Top level of the motor speed Kalman estimator: sequencer, shared multiplier,
// filter state and APB registers. Depends on mske_pkg and mske_div.
//
//   channel | direction | handshake            | beat
//   s_      | in        | s_valid / s_ready    | mske_pkg::in_beat_t
//   m_      | out       | m_valid / m_ready    | mske_pkg::out_beat_t
//   apb     | in        | psel/penable/pready  | 32-bit registers at 4*i
//
// A query or skipped report ends after the estimate step; a corrected report
// also runs the correction, with two gain divisions at one bit a cycle.
// Every product is formed by the one 32x32 multiplier, one product a cycle.
// Reset is synchronous; the predicted covariance returns to identity and the corrected covariance to zero.
// A result waiting on m_ready stalls only the final step of the next beat.
`default_nettype none

module motor_speed_kalman_estimator_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mske_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mske_pkg::out_beat_t      m_data,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int AW = mske_pkg::ACC_W;

    mske_pkg::state_t    state_reg, state_next;
    mske_pkg::in_beat_t  in_reg;
    mske_pkg::out_beat_t out_reg;
    logic                m_valid_reg;

    logic signed [31:0] scale_reg;
    logic [30:0]        qv_reg, qa_reg, r_reg;

    logic signed [31:0] ps0_reg, ps1_reg, cs0_reg, cs1_reg;
    logic signed [31:0] pp0_reg, pp1_reg, pp2_reg, cp0_reg, cp1_reg, cp2_reg;
    logic [47:0]        last_time_reg;
    logic               time_seen_reg;
    logic [15:0]        volt_reg;
    logic               volt_known_reg;

    logic signed [31:0] dt_reg, est_reg, y_reg, k0_reg, k1_reg;
    logic signed [AW-1:0] acc_reg;
    logic               skip_reg, s_pos_reg;
    logic [31:0]        den_reg;
    logic signed [63:0] prod_reg;

    logic signed [31:0] mul_a, mul_b;
    logic               div_start, div_done;
    logic signed [31:0] div_num, div_quo;
    logic               fin_load;

    logic               later;
    logic [47:0]        tdiff;
    logic signed [31:0] dt_new;
    logic signed [31:0] prod_t;
    logic signed [AW-1:0] prod_f;
    logic signed [AW-1:0] qv_s, qa_s, r_s, s_sum;

    always_comb begin
        later  = in_reg.time_stamp > last_time_reg;
        tdiff  = in_reg.time_stamp - last_time_reg;
        dt_new = (tdiff > 48'h00007fffffff) ? 32'sh7fffffff : {1'b0, tdiff[30:0]};
        prod_t = mske_pkg::sat32(AW'(prod_reg >>> mske_pkg::TIME_FRAC));
        prod_f = AW'(prod_reg >>> FRAC_BITS);
        qv_s   = $signed({{(AW-31){1'b0}}, qv_reg});
        qa_s   = $signed({{(AW-31){1'b0}}, qa_reg});
        r_s    = $signed({{(AW-31){1'b0}}, r_reg});
        s_sum  = AW'(pp0_reg) + r_s;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mske_pkg::ST_IDLE: if (s_valid) state_next = mske_pkg::ST_TIME;
            mske_pkg::ST_TIME: state_next = (later && time_seen_reg) ? mske_pkg::ST_P0
                                                                     : mske_pkg::ST_EST;
            mske_pkg::ST_P0:   state_next = mske_pkg::ST_P1;
            mske_pkg::ST_P1:   state_next = mske_pkg::ST_P2;
            mske_pkg::ST_P2:   state_next = mske_pkg::ST_P3;
            mske_pkg::ST_P3:   state_next = mske_pkg::ST_P4;
            mske_pkg::ST_P4:   state_next = mske_pkg::ST_EST;
            mske_pkg::ST_EST: begin
                if (in_reg.mode == mske_pkg::MODE_REPORT && !skip_reg) begin
                    state_next = mske_pkg::ST_C0;
                end else begin
                    state_next = mske_pkg::ST_FIN;
                end
            end
            mske_pkg::ST_C0:   state_next = mske_pkg::ST_C1;
            mske_pkg::ST_C1:   state_next = mske_pkg::ST_CD0;
            mske_pkg::ST_CD0:  if (div_done) state_next = mske_pkg::ST_CD1;
            mske_pkg::ST_CD1:  if (div_done) state_next = mske_pkg::ST_C2;
            mske_pkg::ST_C2:   state_next = mske_pkg::ST_C3;
            mske_pkg::ST_C3:   state_next = mske_pkg::ST_C4;
            mske_pkg::ST_C4:   state_next = mske_pkg::ST_C5;
            mske_pkg::ST_C5:   state_next = mske_pkg::ST_C6;
            mske_pkg::ST_C6:   state_next = mske_pkg::ST_C7;
            mske_pkg::ST_C7:   state_next = mske_pkg::ST_FIN;
            mske_pkg::ST_FIN:  if (!m_valid_reg || m_ready) state_next = mske_pkg::ST_IDLE;
            default:           state_next = mske_pkg::ST_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier and divider
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = pp0_reg;
        s_ready   = 1'b0;
        fin_load  = 1'b0;
        unique case (state_reg)
            mske_pkg::ST_IDLE: s_ready = 1'b1;
            mske_pkg::ST_P0: begin
                mul_a = cp2_reg;
                mul_b = dt_reg;
            end
            mske_pkg::ST_P1: begin
                mul_a = cp1_reg;
                mul_b = dt_reg;
            end
            mske_pkg::ST_P2: begin
                mul_a = pp1_reg;
                mul_b = dt_reg;
            end
            mske_pkg::ST_P3: begin
                mul_a = cs1_reg;
                mul_b = dt_reg;
            end
            mske_pkg::ST_C0: begin
                mul_a = in_reg.measured_speed;
                mul_b = scale_reg;
            end
            mske_pkg::ST_C1: div_start = 1'b1;
            mske_pkg::ST_CD0: begin
                div_start = div_done;
                div_num   = pp1_reg;
            end
            mske_pkg::ST_C2: begin
                mul_a = k0_reg;
                mul_b = y_reg;
            end
            mske_pkg::ST_C3: begin
                mul_a = k1_reg;
                mul_b = y_reg;
            end
            mske_pkg::ST_C4: begin
                mul_a = k0_reg;
                mul_b = pp0_reg;
            end
            mske_pkg::ST_C5: begin
                mul_a = k0_reg;
                mul_b = pp1_reg;
            end
            mske_pkg::ST_C6: begin
                mul_a = k1_reg;
                mul_b = pp1_reg;
            end
            mske_pkg::ST_FIN: fin_load = !m_valid_reg || m_ready;
            default: begin
                mul_a = '0;
            end
        endcase
    end

    mske_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (den_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mske_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fin_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_load) begin
            out_reg.velocity_estimate  <= est_reg;
            out_reg.correction_skipped <= skip_reg;
            out_reg.supply_voltage     <= volt_reg;
            out_reg.voltage_known      <= volt_known_reg;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= 32'sd65536;
            qv_reg    <= 31'd655;
            qa_reg    <= 31'd65536;
            r_reg     <= 31'd6554;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                mske_pkg::REG_SPEED_SCALE: scale_reg <= pwdata;
                mske_pkg::REG_NOISE_VEL:   qv_reg    <= pwdata[30:0];
                mske_pkg::REG_NOISE_ACC:   qa_reg    <= pwdata[30:0];
                mske_pkg::REG_NOISE_MEAS:  r_reg     <= pwdata[30:0];
                default:                   scale_reg <= scale_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            mske_pkg::REG_SPEED_SCALE: prdata = scale_reg;
            mske_pkg::REG_NOISE_VEL:   prdata = {1'b0, qv_reg};
            mske_pkg::REG_NOISE_ACC:   prdata = {1'b0, qa_reg};
            mske_pkg::REG_NOISE_MEAS:  prdata = {1'b0, r_reg};
            default:                   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Filter state and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ps0_reg        <= '0;
            ps1_reg        <= '0;
            cs0_reg        <= '0;
            cs1_reg        <= '0;
            pp0_reg        <= 32'sd1 <<< FRAC_BITS;
            pp1_reg        <= '0;
            pp2_reg        <= 32'sd1 <<< FRAC_BITS;
            cp0_reg        <= '0;
            cp1_reg        <= '0;
            cp2_reg        <= '0;
            last_time_reg  <= '0;
            time_seen_reg  <= 1'b0;
            volt_reg       <= '0;
            volt_known_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                mske_pkg::ST_IDLE: begin
                    if (s_valid) in_reg <= s_data;
                end
                mske_pkg::ST_TIME: begin
                    if (in_reg.mode == mske_pkg::MODE_REPORT) begin
                        volt_reg       <= in_reg.supply_voltage_in;
                        volt_known_reg <= 1'b1;
                    end
                    if (later) begin
                        last_time_reg <= in_reg.time_stamp;
                        time_seen_reg <= 1'b1;
                        dt_reg        <= dt_new;
                    end
                    skip_reg <= (in_reg.mode == mske_pkg::MODE_REPORT) && !later;
                end
                mske_pkg::ST_P1: pp1_reg <= mske_pkg::sat32(AW'(cp1_reg) + AW'(prod_t));
                mske_pkg::ST_P2: acc_reg <= AW'(cp0_reg) + AW'(prod_t) + qv_s;
                mske_pkg::ST_P3: pp0_reg <= mske_pkg::sat32(acc_reg + AW'(prod_t));
                mske_pkg::ST_P4: begin
                    ps0_reg <= mske_pkg::sat32(AW'(cs0_reg) + AW'(prod_t));
                    cs0_reg <= mske_pkg::sat32(AW'(cs0_reg) + AW'(prod_t));
                    ps1_reg <= cs1_reg;
                    pp2_reg <= mske_pkg::sat32(AW'(cp2_reg) + qa_s);
                    cp2_reg <= mske_pkg::sat32(AW'(cp2_reg) + qa_s);
                    cp0_reg <= pp0_reg;
                    cp1_reg <= pp1_reg;
                end
                mske_pkg::ST_EST: est_reg <= ps0_reg;
                mske_pkg::ST_C0: begin
                    s_pos_reg <= s_sum > AW'(0);
                    den_reg   <= s_sum[31:0];
                end
                mske_pkg::ST_C1: begin
                    y_reg <= mske_pkg::sat32(AW'(mske_pkg::sat32(AW'(prod_reg)))
                                             - AW'(ps0_reg));
                end
                mske_pkg::ST_CD0: begin
                    if (div_done) k0_reg <= s_pos_reg ? div_quo : 32'sd0;
                end
                mske_pkg::ST_CD1: begin
                    if (div_done) k1_reg <= s_pos_reg ? div_quo : 32'sd0;
                end
                mske_pkg::ST_C3: cs0_reg <= mske_pkg::sat32(AW'(ps0_reg) + prod_f);
                mske_pkg::ST_C4: cs1_reg <= mske_pkg::sat32(AW'(ps1_reg) + prod_f);
                mske_pkg::ST_C5: cp0_reg <= mske_pkg::sat32(AW'(pp0_reg) - prod_f);
                mske_pkg::ST_C6: cp1_reg <= mske_pkg::sat32(AW'(pp1_reg) - prod_f);
                mske_pkg::ST_C7: cp2_reg <= mske_pkg::sat32(AW'(pp2_reg) - prod_f);
                default: begin
                    volt_reg <= volt_reg;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_div_done_in_gain_step: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == mske_pkg::ST_CD0 || state_reg == mske_pkg::ST_CD1))
        else $error("divider finished outside a gain step");

    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == mske_pkg::ST_FIN))
        else $error("result beat raised outside the final step");

    a_time_seen_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        time_seen_reg |=> time_seen_reg)
        else $error("time seen flag cleared without reset");

    a_skip_no_correct: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mske_pkg::ST_EST && skip_reg) |=> state_reg == mske_pkg::ST_FIN)
        else $error("skipped report went on to correction");

endmodule

`default_nettype wire

@@ hdl/mske_div.sv @@
// Iterative signed divider for the Kalman gain: (num << FRAC_BITS) / den,
// one quotient bit a cycle, saturated to 32 bits. Depends on nothing.
`default_nettype none

module mske_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic [31:0]        den,
    output logic                    done,
    output logic signed [31:0]      quo
);

    localparam int NW = 32 + FRAC_BITS;

    logic              busy_reg, busy_next;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [31:0]       rem_reg, lo_reg, q_reg, den_reg;
    logic              neg_reg, ovf_reg;

    logic [31:0]       mag;
    logic [NW-1:0]     n_full;
    logic [31:0]       hi;
    logic [32:0]       trial;
    logic [32:0]       diff;
    logic              ge;

    always_comb begin
        mag    = num[31] ? (32'd0 - num) : num;
        n_full = {mag, {FRAC_BITS{1'b0}}};
        hi     = {{(32-FRAC_BITS){1'b0}}, n_full[NW-1:32]};
        trial  = {rem_reg, lo_reg[31]};
        diff   = trial - {1'b0, den_reg};
        ge     = trial >= {1'b0, den_reg};
    end

    assign busy_next = start || (busy_reg && (cnt_reg != 5'd31));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= busy_reg && !start && (cnt_reg == 5'd31);
            if (start) begin
                cnt_reg <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= hi;
            lo_reg  <= n_full[31:0];
            q_reg   <= '0;
            den_reg <= den;
            neg_reg <= num[31];
            ovf_reg <= hi >= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            lo_reg  <= {lo_reg[30:0], 1'b0};
            q_reg   <= {q_reg[30:0], ge};
        end
    end

    always_comb begin
        if (!neg_reg) begin
            quo = (ovf_reg || q_reg[31]) ? 32'sh7fffffff : q_reg;
        end else begin
            quo = (ovf_reg || (q_reg[31] && (|q_reg[30:0]))) ? 32'sh80000000
                                                              : (32'd0 - q_reg);
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire
